@@ hw/rtl/spq_pkg.sv @@
// shared types and codes for the sorted priority queue
package spq_pkg;

	// operation codes
	localparam logic OP_ENQ = 1'b0;
	localparam logic OP_DEQ = 1'b1;

	// result status codes
	localparam logic [1:0] STATUS_DONE  = 2'd0;
	localparam logic [1:0] STATUS_FULL  = 2'd1;
	localparam logic [1:0] STATUS_EMPTY = 2'd2;

	localparam int VALUE_W = 32;
	localparam int PRIO_W  = 16;
	localparam int COUNT_W = 7;

	// input item
	typedef struct packed {
		logic                       op;
		logic signed [VALUE_W-1:0]  value_in;
		logic signed [PRIO_W-1:0]   prio_in;
	} in_t;

	// result item
	typedef struct packed {
		logic signed [VALUE_W-1:0]  value_out;
		logic signed [VALUE_W-1:0]  head_value;
		logic [1:0]                 status;
		logic [COUNT_W-1:0]         count;
		logic                       is_empty;
		logic                       is_full;
	} out_t;

	// controller to datapath commands
	typedef struct packed {
		logic latch;     // take the input transfer into the work registers
		logic rd_en;     // issue a memory read
		logic rd_shift;  // read two slots below the insert position
		logic rd_next;   // read the entry behind the current head
		logic shift_wr;  // move the read entry up by one slot
		logic ins_wr;    // write the new entry at the insert position
		logic deq;       // drop the head entry
		logic head_load; // take the read value as the new head value
		logic rej_full;  // record a rejected enqueue
		logic rej_empty; // record a rejected dequeue
		logic out_load;  // load the result register
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic op;
		logic full;
		logic empty;
		logic one_left;  // exactly one entry held
		logic pos_zero;  // insert position is the head
		logic pos_le1;   // insert position at or below one
		logic prio_gt;   // read priority above the new priority
		logic out_free;  // result register can take a new result
	} sts_t;

endpackage

@@ hw/rtl/spq_ctrl.sv @@
// sequencing state machine for the sorted priority queue
module spq_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  spq_pkg::sts_t sts,
	output spq_pkg::cmd_t cmd
);

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_DECODE   = 3'd1;
	localparam logic [2:0] S_ENQ_CMP  = 3'd2;
	localparam logic [2:0] S_ENQ_INS  = 3'd3;
	localparam logic [2:0] S_DEQ_HEAD = 3'd4;
	localparam logic [2:0] S_FIN      = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_ready = (state_q == S_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_DECODE;
				end
			end
			S_DECODE: begin
				if (sts.op == spq_pkg::OP_ENQ) begin
					if (sts.full) begin
						cmd.rej_full = 1'b1;
						state_d      = S_FIN;
					end else if (sts.pos_zero) begin
						cmd.ins_wr = 1'b1;
						state_d    = S_FIN;
					end else begin
						cmd.rd_en = 1'b1;
						state_d   = S_ENQ_CMP;
					end
				end else begin
					if (sts.empty) begin
						cmd.rej_empty = 1'b1;
						state_d       = S_FIN;
					end else if (sts.one_left) begin
						cmd.deq = 1'b1;
						state_d = S_FIN;
					end else begin
						cmd.deq     = 1'b1;
						cmd.rd_en   = 1'b1;
						cmd.rd_next = 1'b1;
						state_d     = S_DEQ_HEAD;
					end
				end
			end
			S_ENQ_CMP: begin
				// move one larger-priority entry up per cycle
				if (sts.prio_gt) begin
					cmd.shift_wr = 1'b1;
					if (sts.pos_le1) begin
						state_d = S_ENQ_INS;
					end else begin
						cmd.rd_en    = 1'b1;
						cmd.rd_shift = 1'b1;
					end
				end else begin
					cmd.ins_wr = 1'b1;
					state_d    = S_FIN;
				end
			end
			S_ENQ_INS: begin
				cmd.ins_wr = 1'b1;
				state_d    = S_FIN;
			end
			S_DEQ_HEAD: begin
				cmd.head_load = 1'b1;
				state_d       = S_FIN;
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ hw/rtl/spq_dp.sv @@
// storage, pointers and result register of the sorted priority queue
module spq_dp #(
	parameter int CAPACITY = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  spq_pkg::in_t   in_data,
	input  spq_pkg::cmd_t  cmd,
	output spq_pkg::sts_t  sts,
	output logic           out_valid,
	input  logic           out_ready,
	output spq_pkg::out_t  out_data
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	// entry memories, indexed by physical slot
	logic [spq_pkg::VALUE_W-1:0]        val_mem [CAPACITY];
	logic signed [spq_pkg::PRIO_W-1:0]  prio_mem [CAPACITY];

	logic [AW-1:0]                      head_q;
	logic [CW-1:0]                      count_q;
	logic [CW-1:0]                      pos_q;
	logic                               op_q;
	logic [spq_pkg::VALUE_W-1:0]        val_q;
	logic signed [spq_pkg::PRIO_W-1:0]  prio_q;
	logic [spq_pkg::VALUE_W-1:0]        head_val_q;
	logic [spq_pkg::VALUE_W-1:0]        removed_q;
	logic [1:0]                         status_q;
	logic [spq_pkg::VALUE_W-1:0]        rd_val_q;
	logic signed [spq_pkg::PRIO_W-1:0]  rd_prio_q;
	logic                               out_valid_q;
	spq_pkg::out_t                      out_q;

	logic [CW-1:0]                      rd_lg;
	logic [AW-1:0]                      rd_addr;
	logic [AW-1:0]                      wr_addr;
	logic                               wr_en;
	logic [spq_pkg::VALUE_W-1:0]        wr_val;
	logic signed [spq_pkg::PRIO_W-1:0]  wr_prio;
	logic [AW-1:0]                      head_inc;

	// logical position to physical slot, wrapping at the capacity
	function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
	                                       input logic [AW-1:0] lg);
		logic [AW:0] s;
		s = {1'b0, base} + {1'b0, lg};
		if (s >= (AW+1)'(CAPACITY)) begin
			s = s - (AW+1)'(CAPACITY);
		end
		return s[AW-1:0];
	endfunction

	assign head_inc = (head_q == AW'(CAPACITY - 1)) ? '0 : head_q + 1'b1;

	// read address: head successor, or one or two below the insert position
	always_comb begin
		if (cmd.rd_next) begin
			rd_lg = CW'(1);
		end else if (cmd.rd_shift) begin
			rd_lg = pos_q - CW'(2);
		end else begin
			rd_lg = pos_q - CW'(1);
		end
	end
	assign rd_addr = phys(head_q, rd_lg[AW-1:0]);

	// write port: either a shifted entry or the new entry
	assign wr_en   = cmd.shift_wr | cmd.ins_wr;
	assign wr_addr = phys(head_q, pos_q[AW-1:0]);
	assign wr_val  = cmd.shift_wr ? rd_val_q : val_q;
	assign wr_prio = cmd.shift_wr ? rd_prio_q : prio_q;

	// entry memories
	always_ff @(posedge clk) begin
		if (wr_en) begin
			val_mem[wr_addr]  <= wr_val;
			prio_mem[wr_addr] <= wr_prio;
		end
		if (cmd.rd_en) begin
			rd_val_q  <= val_mem[rd_addr];
			rd_prio_q <= prio_mem[rd_addr];
		end
	end

	// queue control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.ins_wr) begin
				count_q <= count_q + 1'b1;
			end else if (cmd.deq) begin
				count_q <= count_q - 1'b1;
				head_q  <= head_inc;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// work registers of the item in flight
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q      <= in_data.op;
			val_q     <= in_data.value_in;
			prio_q    <= in_data.prio_in;
			pos_q     <= count_q;
			removed_q <= '0;
			status_q  <= spq_pkg::STATUS_DONE;
		end else begin
			if (cmd.shift_wr) begin
				pos_q <= pos_q - 1'b1;
			end
			if (cmd.rej_full) begin
				status_q <= spq_pkg::STATUS_FULL;
			end else if (cmd.rej_empty) begin
				status_q <= spq_pkg::STATUS_EMPTY;
			end
			if (cmd.deq) begin
				removed_q <= head_val_q;
			end
		end
		// head value tracks inserts at the front and dequeue refills
		if (cmd.ins_wr && pos_q == '0) begin
			head_val_q <= val_q;
		end else if (cmd.head_load) begin
			head_val_q <= rd_val_q;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.value_out  <= removed_q;
			out_q.head_value <= (count_q == '0) ? '0 : head_val_q;
			out_q.status     <= status_q;
			out_q.count      <= spq_pkg::COUNT_W'(count_q);
			out_q.is_empty   <= (count_q == '0);
			out_q.is_full    <= (count_q == CW'(CAPACITY));
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// status to the controller
	assign sts.op       = op_q;
	assign sts.full     = (count_q == CW'(CAPACITY));
	assign sts.empty    = (count_q == '0);
	assign sts.one_left = (count_q == CW'(1));
	assign sts.pos_zero = (pos_q == '0);
	assign sts.pos_le1  = (pos_q <= CW'(1));
	assign sts.prio_gt  = (rd_prio_q > prio_q);
	assign sts.out_free = !out_valid_q || out_ready;

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_ins_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins_wr |-> count_q < CW'(CAPACITY))
		else $error("insert into a full queue");

	a_deq_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.deq |-> count_q != '0)
		else $error("dequeue from an empty queue");

	a_shift_pos: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.shift_wr |-> (pos_q != '0 && !cmd.ins_wr))
		else $error("shift at the head or together with insert");

endmodule

@@ hw/rtl/sorted_priority_queue.sv @@
// Sorted priority queue: one enqueue or dequeue per transfer, one result per item.
// Entries sit in a circular buffer kept sorted by priority, so a dequeue only moves the
// head pointer and refills the head value with one memory read; a dequeue that leaves the
// queue empty needs no read. An enqueue walks from the tail towards the head, moving
// one entry of larger priority up a slot per cycle through the single write port and
// registered read port, until it meets an entry whose priority is not above the new one.
// An enqueue into an empty queue writes at once, and one into a full queue is rejected.
// A new input transfer is taken once the previous result has been loaded into the
// output register, even while that result still waits to be taken. Equal priorities
// leave in arrival order. No clearing pass is needed after reset.
module sorted_priority_queue #(
	parameter int CAPACITY = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  spq_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output spq_pkg::out_t out_data
);

	spq_pkg::cmd_t cmd;
	spq_pkg::sts_t sts;

	// sequencer
	spq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// storage and result path
	spq_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
